/* sv/xcqi_pkg.sv */
package xcqi_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned MAX_SOURCES_DEF = 16;
  localparam int unsigned FIFO_DEPTH      = 2;
  localparam int unsigned NSRC_W          = 5;
  localparam int unsigned GO_W            = 5;
  localparam logic [GO_W-1:0] GO_BIT_RESET = 5'd31;

  localparam logic RK_WORD   = 1'b0;
  localparam logic RK_REPORT = 1'b1;

  typedef enum logic [1:0] {
    RT_HEADER = 2'd0,
    RT_SOURCE = 2'd1,
    RT_DONE   = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_TOO_MANY = 2'd2,
    ST_SPURIOUS = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_TAG,
    BS_LEN,
    BS_SRC,
    BS_DEST,
    BS_REPORT
  } back_state_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [31:0]       dest_addr;
    logic [31:0]       byte_length;
    logic [NSRC_W-1:0] num_sources;
    logic [31:0]       src_addr;
    logic [15:0]       req_tag;
  } req_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] fifo_word;
    logic [1:0]  done_status;
    logic [15:0] done_tag;
    logic        last_of_run;
  } rsp_t;

  typedef struct packed {
    logic [31:0]       dest;
    logic [31:0]       length;
    logic [NSRC_W-1:0] count;
    logic [15:0]       tag;
  } meta_t;

  typedef struct packed {
    logic        issue;
    logic        report;
    logic        tag_from_ring;
    status_e     status;
    logic [15:0] tag;
  } cmd_t;

endpackage

/* sv/xcqi_fifo.sv */
module xcqi_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);

  logic [W-1:0]    mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_d  = push_i ? next_ptr(wr_q) : wr_q;
    rd_d  = pop_i ? next_ptr(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);

endmodule

/* sv/xcqi_ring.sv */
module xcqi_ring #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned MAX_SOURCES = 16,
  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH),
  localparam int unsigned SaW  = $clog2(QUEUE_DEPTH * MAX_SOURCES)
) (
  input  logic                  clk_i,
  input  logic                  meta_we_i,
  input  logic [IdxW-1:0]       meta_waddr_i,
  input  xcqi_pkg::meta_t       meta_wdata_i,
  input  logic [IdxW-1:0]       meta_raddr_i,
  output xcqi_pkg::meta_t       meta_rdata_o,
  input  logic                  src_we_i,
  input  logic [SaW-1:0]        src_waddr_i,
  input  logic [31:0]           src_wdata_i,
  input  logic [SaW-1:0]        src_raddr_i,
  output logic [31:0]           src_rdata_o
);
  import xcqi_pkg::*;

  meta_t       meta_mem [QUEUE_DEPTH];
  logic [31:0] src_mem  [QUEUE_DEPTH * MAX_SOURCES];

  always_ff @(posedge clk_i) begin
    if (meta_we_i) begin
      meta_mem[meta_waddr_i] <= meta_wdata_i;
    end
    meta_rdata_o <= meta_mem[meta_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (src_we_i) begin
      src_mem[src_waddr_i] <= src_wdata_i;
    end
    src_rdata_o <= src_mem[src_raddr_i];
  end

endmodule

/* sv/xcqi_front.sv */
module xcqi_front #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned MAX_SOURCES = 16,
  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH),
  localparam int unsigned SaW  = $clog2(QUEUE_DEPTH * MAX_SOURCES),
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  xcqi_pkg::req_t    req_i,
  output logic              push_o,
  output xcqi_pkg::cmd_t    cmd_o,
  output logic [IdxW-1:0]   issue_idx_o,
  output logic [IdxW-1:0]   tag_idx_o,
  output logic              meta_we_o,
  output logic [IdxW-1:0]   meta_waddr_o,
  output xcqi_pkg::meta_t   meta_wdata_o,
  output logic              src_we_o,
  output logic [SaW-1:0]    src_waddr_o,
  output logic [31:0]       src_wdata_o
);
  import xcqi_pkg::*;

  logic [IdxW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              eng_busy_q, eng_busy_d;
  logic [NSRC_W-1:0] pend_q, pend_d, pos_q, pos_d;
  logic              commit;

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] i);
    return (i == IdxW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    eng_busy_d   = eng_busy_q;
    pend_d       = pend_q;
    pos_d        = pos_q;
    commit       = 1'b0;
    push_o       = 1'b0;
    cmd_o        = '0;
    issue_idx_o  = head_q;
    tag_idx_o    = head_q;
    meta_we_o    = 1'b0;
    meta_waddr_o = tail_q;
    meta_wdata_o = '{dest: req_i.dest_addr, length: req_i.byte_length,
                     count: req_i.num_sources, tag: req_i.req_tag};
    src_we_o     = 1'b0;
    src_waddr_o  = SaW'(tail_q) * SaW'(MAX_SOURCES) + SaW'(pos_q);
    src_wdata_o  = req_i.src_addr;

    if (accept_i) begin
      case (req_i.req_type)
        RT_HEADER: begin
          pend_d = '0;
          pos_d  = '0;
          if (count_q == CntW'(QUEUE_DEPTH)) begin
            push_o        = 1'b1;
            cmd_o.report  = 1'b1;
            cmd_o.status  = ST_FULL;
            cmd_o.tag     = req_i.req_tag;
          end else if (req_i.num_sources > NSRC_W'(MAX_SOURCES)) begin
            push_o        = 1'b1;
            cmd_o.report  = 1'b1;
            cmd_o.status  = ST_TOO_MANY;
            cmd_o.tag     = req_i.req_tag;
          end else begin
            meta_we_o = 1'b1;
            if (req_i.num_sources == '0) begin
              commit = 1'b1;
            end else begin
              pend_d = req_i.num_sources;
            end
          end
        end
        RT_SOURCE: begin
          if (pend_q != '0 && pos_q < NSRC_W'(MAX_SOURCES)) begin
            src_we_o = 1'b1;
            pos_d    = pos_q + 1'b1;
            pend_d   = pend_q - 1'b1;
            if (pend_q == NSRC_W'(1)) begin
              commit = 1'b1;
            end
          end
        end
        RT_DONE: begin
          push_o       = 1'b1;
          cmd_o.report = 1'b1;
          if (count_q != '0) begin
            head_d              = next_idx(head_q);
            count_d             = count_q - 1'b1;
            eng_busy_d          = 1'b0;
            cmd_o.status        = ST_OK;
            cmd_o.tag_from_ring = 1'b1;
            tag_idx_o           = head_q;
            if (count_q > CntW'(1)) begin
              eng_busy_d  = 1'b1;
              cmd_o.issue = 1'b1;
              issue_idx_o = next_idx(head_q);
            end
          end else begin
            cmd_o.status = ST_SPURIOUS;
          end
        end
        default: ;
      endcase

      if (commit) begin
        tail_d  = next_idx(tail_q);
        count_d = count_q + 1'b1;
        pend_d  = '0;
        pos_d   = '0;
        if (!eng_busy_q) begin
          eng_busy_d  = 1'b1;
          push_o      = 1'b1;
          cmd_o.issue = 1'b1;
          issue_idx_o = head_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      eng_busy_q <= 1'b0;
      pend_q     <= '0;
      pos_q      <= '0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      eng_busy_q <= eng_busy_d;
      pend_q     <= pend_d;
      pos_q      <= pos_d;
    end
  end

endmodule

/* sv/xcqi_back.sv */
module xcqi_back #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned MAX_SOURCES = 16,
  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH),
  localparam int unsigned SaW  = $clog2(QUEUE_DEPTH * MAX_SOURCES)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [xcqi_pkg::GO_W-1:0] go_i,
  input  logic                      fifo_empty_i,
  input  xcqi_pkg::cmd_t            head_cmd_i,
  input  logic [IdxW-1:0]           head_issue_idx_i,
  input  logic [IdxW-1:0]           head_tag_idx_i,
  output logic                      pop_o,
  output logic [IdxW-1:0]           meta_raddr_o,
  input  xcqi_pkg::meta_t           meta_rdata_i,
  output logic [SaW-1:0]            src_raddr_o,
  input  logic [31:0]               src_rdata_i,
  output logic                      active_o,
  output logic                      rsp_valid_o,
  output xcqi_pkg::rsp_t            rsp_o
);
  import xcqi_pkg::*;

  back_state_e       state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [15:0]       tag_q, tag_d;
  logic [31:0]       dest_q, dest_d;
  logic [NSRC_W-1:0] left_q, left_d;
  logic [SaW-1:0]    ptr_q, ptr_d, base;
  logic              valid_q, valid_d;
  rsp_t              rsp_q, rsp_d;

  assign base = SaW'(idx_q) * SaW'(MAX_SOURCES);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    tag_d        = tag_q;
    dest_d       = dest_q;
    left_d       = left_q;
    ptr_d        = ptr_q;
    pop_o        = 1'b0;
    meta_raddr_o = idx_q;
    src_raddr_o  = ptr_q;
    valid_d      = 1'b0;
    rsp_d        = '0;

    unique case (state_q)
      BS_IDLE: begin
        meta_raddr_o = head_cmd_i.tag_from_ring ? head_tag_idx_i : head_issue_idx_i;
        if (!fifo_empty_i) begin
          pop_o = 1'b1;
          cmd_d = head_cmd_i;
          idx_d = head_issue_idx_i;
          if (head_cmd_i.tag_from_ring) begin
            state_d = BS_TAG;
          end else if (head_cmd_i.issue) begin
            state_d = BS_LEN;
          end else begin
            state_d = BS_REPORT;
          end
        end
      end
      BS_TAG: begin
        tag_d   = meta_rdata_i.tag;
        state_d = cmd_q.issue ? BS_LEN : BS_REPORT;
      end
      BS_LEN: begin
        valid_d           = 1'b1;
        rsp_d.result_kind = RK_WORD;
        rsp_d.fifo_word   = {2'b00, meta_rdata_i.length[31:2]};
        dest_d            = meta_rdata_i.dest;
        left_d            = meta_rdata_i.count;
        src_raddr_o       = base;
        ptr_d             = base + 1'b1;
        state_d           = (meta_rdata_i.count == '0) ? BS_DEST : BS_SRC;
      end
      BS_SRC: begin
        valid_d           = 1'b1;
        rsp_d.result_kind = RK_WORD;
        rsp_d.fifo_word   = {2'b00, src_rdata_i[31:2]};
        ptr_d             = ptr_q + 1'b1;
        left_d            = left_q - 1'b1;
        if (left_q == NSRC_W'(1)) begin
          state_d = BS_DEST;
        end
      end
      BS_DEST: begin
        valid_d           = 1'b1;
        rsp_d.result_kind = RK_WORD;
        rsp_d.fifo_word   = {2'b00, dest_q[31:2]} | (32'd1 << go_i);
        rsp_d.last_of_run = !cmd_q.report;
        state_d           = cmd_q.report ? BS_REPORT : BS_IDLE;
      end
      BS_REPORT: begin
        valid_d           = 1'b1;
        rsp_d.result_kind = RK_REPORT;
        rsp_d.done_status = cmd_q.status;
        rsp_d.done_tag    = cmd_q.tag_from_ring ? tag_q : cmd_q.tag;
        rsp_d.last_of_run = 1'b1;
        state_d           = BS_IDLE;
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      cmd_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    tag_q  <= tag_d;
    dest_q <= dest_d;
    left_q <= left_d;
    ptr_q  <= ptr_d;
    rsp_q  <= rsp_d;
  end

  assign active_o    = (state_q != BS_IDLE);
  assign rsp_valid_o = valid_q;
  assign rsp_o       = rsp_q;

endmodule

/* sv/xor_command_queue_issuer.sv */
// the first result follows start through the command FIFO, the back-end state and the result register,
// and a completion first reads the ring for its tag; an issuing item gives one word per cycle
// (length, each source, then dest), and items with no result never enter the command FIFO
// results are strobed for one cycle each; the receiver cannot stall
// reset clears queue pointers, counts and engine state, go bit position returns to 31;
// ring contents are undefined until written
module xor_command_queue_issuer #(
  parameter int unsigned QUEUE_DEPTH = xcqi_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_SOURCES = xcqi_pkg::MAX_SOURCES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  xcqi_pkg::req_t            req_i,
  input  logic                      cfg_we_i,
  input  logic [xcqi_pkg::GO_W-1:0] cfg_wdata_i,
  output logic                      rsp_valid_o,
  output xcqi_pkg::rsp_t            rsp_o
);
  import xcqi_pkg::*;

  localparam int unsigned IdxW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned SaW   = $clog2(QUEUE_DEPTH * MAX_SOURCES);
  localparam int unsigned QentW = $bits(cmd_t) + 2 * IdxW;

  logic [GO_W-1:0]  go_q;
  logic             accept;
  logic             push, pop, fifo_empty, back_active;
  cmd_t             push_cmd, head_cmd;
  logic [IdxW-1:0]  push_issue_idx, push_tag_idx, head_issue_idx, head_tag_idx;
  logic [QentW-1:0] fifo_rdata;
  logic             meta_we, src_we;
  logic [IdxW-1:0]  meta_waddr, meta_raddr;
  meta_t            meta_wdata, meta_rdata;
  logic [SaW-1:0]   src_waddr, src_raddr;
  logic [31:0]      src_wdata, src_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q <= GO_BIT_RESET;
    end else if (cfg_we_i) begin
      go_q <= cfg_wdata_i;
    end
  end

  assign accept = start && !busy;
  assign busy   = !fifo_empty || back_active;

  xcqi_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_SOURCES(MAX_SOURCES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_i        (req_i),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .issue_idx_o  (push_issue_idx),
    .tag_idx_o    (push_tag_idx),
    .meta_we_o    (meta_we),
    .meta_waddr_o (meta_waddr),
    .meta_wdata_o (meta_wdata),
    .src_we_o     (src_we),
    .src_waddr_o  (src_waddr),
    .src_wdata_o  (src_wdata)
  );

  xcqi_fifo #(
    .W    (QentW),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({push_cmd, push_issue_idx, push_tag_idx}),
    .pop_i   (pop),
    .rdata_o (fifo_rdata),
    .empty_o (fifo_empty)
  );

  assign {head_cmd, head_issue_idx, head_tag_idx} = fifo_rdata;

  xcqi_ring #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_SOURCES(MAX_SOURCES)
  ) u_ring (
    .clk_i        (clk_i),
    .meta_we_i    (meta_we),
    .meta_waddr_i (meta_waddr),
    .meta_wdata_i (meta_wdata),
    .meta_raddr_i (meta_raddr),
    .meta_rdata_o (meta_rdata),
    .src_we_i     (src_we),
    .src_waddr_i  (src_waddr),
    .src_wdata_i  (src_wdata),
    .src_raddr_i  (src_raddr),
    .src_rdata_o  (src_rdata)
  );

  xcqi_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_SOURCES(MAX_SOURCES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .go_i             (go_q),
    .fifo_empty_i     (fifo_empty),
    .head_cmd_i       (head_cmd),
    .head_issue_idx_i (head_issue_idx),
    .head_tag_idx_i   (head_tag_idx),
    .pop_o            (pop),
    .meta_raddr_o     (meta_raddr),
    .meta_rdata_i     (meta_rdata),
    .src_raddr_o      (src_raddr),
    .src_rdata_i      (src_rdata),
    .active_o         (back_active),
    .rsp_valid_o      (rsp_valid_o),
    .rsp_o            (rsp_o)
  );

`ifndef SYNTHESIS
  a_report_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.result_kind == RK_REPORT |-> rsp_o.last_of_run)
    else $error("completion report not marked as end of run");

  a_word_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.result_kind == RK_WORD |->
      rsp_o.done_status == ST_OK && rsp_o.done_tag == 16'd0)
    else $error("control word carries status or tag");

  a_run_holds_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.last_of_run |-> busy)
    else $error("unfinished transaction run with busy low");
`endif

endmodule
